/* hdl/bcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery cell monitor package
// Shared constants, register map, status codes and bus types.
// ----------------------------------------------------------------------------
package bcm_pkg;

  // Default number of series cells that the counter looks for.
  localparam int MAX_CELLS_DEF = 6;

  // Configuration port geometry.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes.
  localparam logic [2:0] REG_PACK_GAIN   = 3'd0;
  localparam logic [2:0] REG_ADC_REF     = 3'd1;
  localparam logic [2:0] REG_CELL_FULL   = 3'd2;
  localparam logic [2:0] REG_CELL_WARN   = 3'd3;
  localparam logic [2:0] REG_CELL_EMPTY  = 3'd4;
  localparam logic [2:0] REG_SETTLE_BAND = 3'd5;

  // Register reset values.
  localparam logic [23:0] RST_PACK_GAIN   = 24'd580000;
  localparam logic [11:0] RST_ADC_REF     = 12'd3300;
  localparam logic [12:0] RST_CELL_FULL   = 13'd4200;
  localparam logic [12:0] RST_CELL_WARN   = 13'd3500;
  localparam logic [12:0] RST_CELL_EMPTY  = 13'd3300;
  localparam logic [9:0]  RST_SETTLE_BAND = 10'd100;

  // Pack status codes.
  localparam logic [1:0] STAT_NC   = 2'd0;
  localparam logic [1:0] STAT_OK   = 2'd1;
  localparam logic [1:0] STAT_LOW  = 2'd2;
  localparam logic [1:0] STAT_VLOW = 2'd3;

  // Filter coefficients in Q15 and the rounding term.
  localparam logic [30:0] PACK_OLD_Q15 = 31'd29491;
  localparam logic [30:0] PACK_NEW_Q15 = 31'd3277;
  localparam logic [30:0] TEMP_OLD_Q15 = 31'd22938;
  localparam logic [30:0] TEMP_NEW_Q15 = 31'd9830;
  localparam logic signed [43:0] ROUND_Q15 = 44'sd16384;

  // Exact floor division by 4095 for dividends below 2**30:
  // q = (x * ceil(2**42 / 4095)) >> 42.
  localparam logic [30:0] RCP_4095 = 31'd1074004033;

  // Sensor reads 760 mV at 25 C with 400 C/V, so the offset in
  // centidegrees is 30400 - 2500 and the scale is 40 per millivolt.
  localparam logic signed [18:0] TEMP_OFS_CENTI = 19'sd27900;

  // Configuration register values as seen by the datapath.
  typedef struct packed {
    logic [23:0] pack_gain;
    logic [11:0] adc_ref;
    logic [12:0] cell_full;
    logic [12:0] cell_warn;
    logic [12:0] cell_empty;
    logic [9:0]  settle_band;
  } cfg_t;

  // Operands for the shared multiplier.
  typedef struct packed {
    logic signed [31:0] a;
    logic        [30:0] b;
  } mul_op_t;

  // Reciprocal of the cell count for a 16-bit dividend, exact after >> 19.
  // A count of zero divides by one.
  function automatic logic [19:0] cell_recip(input logic [2:0] cnt);
    logic [19:0] r;
    begin
      case (cnt)
        3'd0:    r = 20'd524288;
        3'd1:    r = 20'd524288;
        3'd2:    r = 20'd262144;
        3'd3:    r = 20'd174763;
        3'd4:    r = 20'd131072;
        3'd5:    r = 20'd104858;
        3'd6:    r = 20'd87382;
        3'd7:    r = 20'd74899;
        default: r = 20'd524288;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

/* hdl/bcm_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery cell monitor channel interfaces
// Valid/ready channels for sample requests and status results.
// ----------------------------------------------------------------------------
interface bcm_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pack_sample;
  logic [11:0] temp_sample;

  modport source (output valid, output pack_sample, output temp_sample, input ready);
  modport sink   (input valid, input pack_sample, input temp_sample, output ready);
endinterface

interface bcm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         pack_status;
  logic [2:0]         cell_count;
  logic [15:0]        pack_mv;
  logic [15:0]        cell_mv;
  logic               is_settled;
  logic signed [18:0] die_temp_centi;

  modport source (output valid, output pack_status, output cell_count, output pack_mv,
                  output cell_mv, output is_settled, output die_temp_centi, input ready);
  modport sink   (input valid, input pack_status, input cell_count, input pack_mv,
                  input cell_mv, input is_settled, input die_temp_centi, output ready);
endinterface
`default_nettype wire

/* hdl/bcm_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery cell monitor register file
// APB-style write and read access to the six configuration registers.
// ----------------------------------------------------------------------------
module bcm_cfg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [bcm_pkg::CFG_AW-1:0]   paddr,
  input  wire  [bcm_pkg::CFG_DW-1:0]   pwdata,
  output logic [bcm_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output bcm_pkg::cfg_t                cfg
);

  bcm_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pack_gain   <= bcm_pkg::RST_PACK_GAIN;
      cfg_r.adc_ref     <= bcm_pkg::RST_ADC_REF;
      cfg_r.cell_full   <= bcm_pkg::RST_CELL_FULL;
      cfg_r.cell_warn   <= bcm_pkg::RST_CELL_WARN;
      cfg_r.cell_empty  <= bcm_pkg::RST_CELL_EMPTY;
      cfg_r.settle_band <= bcm_pkg::RST_SETTLE_BAND;
    end else if (wr_en) begin
      case (idx)
        bcm_pkg::REG_PACK_GAIN:   cfg_r.pack_gain   <= pwdata[23:0];
        bcm_pkg::REG_ADC_REF:     cfg_r.adc_ref     <= pwdata[11:0];
        bcm_pkg::REG_CELL_FULL:   cfg_r.cell_full   <= pwdata[12:0];
        bcm_pkg::REG_CELL_WARN:   cfg_r.cell_warn   <= pwdata[12:0];
        bcm_pkg::REG_CELL_EMPTY:  cfg_r.cell_empty  <= pwdata[12:0];
        bcm_pkg::REG_SETTLE_BAND: cfg_r.settle_band <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      bcm_pkg::REG_PACK_GAIN:   prdata = 32'(cfg_r.pack_gain);
      bcm_pkg::REG_ADC_REF:     prdata = 32'(cfg_r.adc_ref);
      bcm_pkg::REG_CELL_FULL:   prdata = 32'(cfg_r.cell_full);
      bcm_pkg::REG_CELL_WARN:   prdata = 32'(cfg_r.cell_warn);
      bcm_pkg::REG_CELL_EMPTY:  prdata = 32'(cfg_r.cell_empty);
      bcm_pkg::REG_SETTLE_BAND: prdata = 32'(cfg_r.settle_band);
      default:                  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/bcm_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery cell monitor shared multiplier
// Signed 32-bit by unsigned 31-bit multiply with a registered product.
// ----------------------------------------------------------------------------
module bcm_mul (
  input  wire                   clk,
  input  bcm_pkg::mul_op_t      op,
  output logic signed [62:0]    prod
);

  logic signed [62:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op.a * $signed({1'b0, op.b});
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

/* hdl/bcm_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery cell monitor sequencer
// Steps one sample request through the shared multiplier, runs the filters,
// the cell counter and the status logic, and holds the result register.
// ----------------------------------------------------------------------------
module bcm_seq #(
  parameter int MAX_CELLS = bcm_pkg::MAX_CELLS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bcm_pkg::cfg_t       cfg,
  output bcm_pkg::mul_op_t    mul_op,
  input  wire signed [62:0]   prod,
  bcm_in_if.sink              in_req,
  bcm_out_if.source           out_req
);

  localparam int KW = $clog2(MAX_CELLS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RAW  = 4'd1;
  localparam logic [3:0] ST_FPM  = 4'd2;
  localparam logic [3:0] ST_RQM  = 4'd3;
  localparam logic [3:0] ST_TSM  = 4'd4;
  localparam logic [3:0] ST_FTM  = 4'd5;
  localparam logic [3:0] ST_RCP  = 4'd6;
  localparam logic [3:0] ST_QUO  = 4'd7;
  localparam logic [3:0] ST_INM  = 4'd8;
  localparam logic [3:0] ST_TMP  = 4'd9;
  localparam logic [3:0] ST_CNT  = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  // Control and model state
  logic [3:0]         state_r, state_nxt;
  logic [23:0]        fp_r, fp_nxt;
  logic signed [27:0] ft_r, ft_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [2:0]         cells_r, cells_nxt;
  logic [15:0]        cmv_r, cmv_nxt;
  logic               settled_r, settled_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers
  logic [11:0]        ps_r, ps_nxt;
  logic [11:0]        ts_r, ts_nxt;
  logic [15:0]        raw_r, raw_nxt;
  logic signed [43:0] acc_r, acc_nxt;
  logic [29:0]        x_r, x_nxt;
  logic signed [18:0] inst_r, inst_nxt;
  logic [15:0]        cdiv_r, cdiv_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [15:0]        lim_r, lim_nxt;

  // Result register
  logic [1:0]         o_status_r;
  logic [2:0]         o_cells_r;
  logic [15:0]        o_pack_r;
  logic [15:0]        o_cell_r;
  logic               o_settled_r;
  logic signed [18:0] o_temp_r;
  logic               out_load;

  // Shared datapath pieces
  logic               in_fire;
  logic signed [43:0] filt_sum;
  logic [23:0]        raw_q8;
  logic [23:0]        diff;
  logic               settled_now;
  logic               cnt_hit;

  assign in_fire  = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);

  // Rounded Q15 filter sum; the new-sample product is shifted up 8 bits.
  assign filt_sum = acc_r + $signed({prod[35:0], 8'b0}) + bcm_pkg::ROUND_Q15;

  assign raw_q8 = {raw_r, 8'b0};
  assign diff   = (fp_r >= raw_q8) ? (fp_r - raw_q8) : (raw_q8 - fp_r);
  assign settled_now = (fp_r != 24'd0) && (diff < {6'b0, cfg.settle_band, 8'b0});
  assign cnt_hit = (fp_r <= {lim_r, 8'b0}) || (k_r == KW'(MAX_CELLS));

  always_comb begin
    mul_op.a = '0;
    mul_op.b = '0;
    case (state_r)
      ST_RAW: begin
        mul_op.a = 32'(ps_r);
        mul_op.b = 31'(cfg.pack_gain);
      end
      ST_FPM: begin
        mul_op.a = 32'(fp_r);
        mul_op.b = bcm_pkg::PACK_OLD_Q15;
      end
      ST_RQM: begin
        mul_op.a = 32'(raw_r);
        mul_op.b = bcm_pkg::PACK_NEW_Q15;
      end
      ST_TSM: begin
        mul_op.a = 32'(ts_r);
        mul_op.b = 31'(cfg.adc_ref);
      end
      ST_FTM: begin
        mul_op.a = 32'(ft_r);
        mul_op.b = bcm_pkg::TEMP_OLD_Q15;
      end
      ST_RCP: begin
        mul_op.a = 32'(x_r);
        mul_op.b = bcm_pkg::RCP_4095;
      end
      ST_QUO: begin
        mul_op.a = 32'(fp_r[23:8]);
        mul_op.b = 31'(bcm_pkg::cell_recip(cells_r));
      end
      ST_INM: begin
        mul_op.a = 32'(inst_r);
        mul_op.b = bcm_pkg::TEMP_NEW_Q15;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    fp_nxt        = fp_r;
    ft_nxt        = ft_r;
    status_nxt    = status_r;
    cells_nxt     = cells_r;
    cmv_nxt       = cmv_r;
    settled_nxt   = settled_r;
    ps_nxt        = ps_r;
    ts_nxt        = ts_r;
    raw_nxt       = raw_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    inst_nxt      = inst_r;
    cdiv_nxt      = cdiv_r;
    k_nxt         = k_r;
    lim_nxt       = lim_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_req.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ps_nxt    = in_req.pack_sample;
          ts_nxt    = in_req.temp_sample;
          state_nxt = ST_RAW;
        end
      end
      ST_RAW: state_nxt = ST_FPM;
      ST_FPM: begin
        raw_nxt   = (prod[35:32] != 4'd0) ? 16'hFFFF : prod[31:16];
        state_nxt = ST_RQM;
      end
      ST_RQM: begin
        acc_nxt   = $signed(prod[43:0]);
        state_nxt = ST_TSM;
      end
      ST_TSM: begin
        fp_nxt    = filt_sum[38:15];
        state_nxt = ST_FTM;
      end
      ST_FTM: begin
        x_nxt     = {prod[24:0], 5'b0} + {2'b0, prod[24:0], 3'b0};
        state_nxt = ST_RCP;
      end
      ST_RCP: begin
        acc_nxt   = $signed(prod[43:0]);
        state_nxt = ST_QUO;
      end
      ST_QUO: begin
        inst_nxt  = $signed({1'b0, prod[59:42]}) - bcm_pkg::TEMP_OFS_CENTI;
        state_nxt = ST_INM;
      end
      ST_INM: begin
        cdiv_nxt  = prod[34:19];
        state_nxt = ST_TMP;
      end
      ST_TMP: begin
        ft_nxt    = filt_sum[42:15];
        state_nxt = ST_DONE;
        if (status_r != bcm_pkg::STAT_NC) begin
          cmv_nxt = cdiv_r;
          if (cdiv_r < 16'(cfg.cell_empty)) begin
            status_nxt = bcm_pkg::STAT_VLOW;
          end else if (cdiv_r < 16'(cfg.cell_warn)) begin
            status_nxt = bcm_pkg::STAT_LOW;
          end
          if (fp_r < {3'b0, cfg.cell_empty, 8'b0}) begin
            status_nxt  = bcm_pkg::STAT_NC;
            settled_nxt = 1'b0;
            cells_nxt   = 3'd0;
            cmv_nxt     = 16'd0;
          end
        end else if (settled_now) begin
          k_nxt     = KW'(1);
          lim_nxt   = 16'(cfg.cell_full);
          state_nxt = ST_CNT;
        end
      end
      ST_CNT: begin
        if (cnt_hit) begin
          settled_nxt = 1'b1;
          state_nxt   = ST_DONE;
          if (raw_r < 16'(cfg.cell_empty)) begin
            cells_nxt = 3'd0;
            cmv_nxt   = 16'd0;
          end else begin
            cells_nxt  = 3'(k_r);
            status_nxt = bcm_pkg::STAT_OK;
          end
        end else begin
          k_nxt   = k_r + KW'(1);
          lim_nxt = lim_r + 16'(cfg.cell_full);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_req.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fp_r        <= '0;
      ft_r        <= '0;
      status_r    <= bcm_pkg::STAT_NC;
      cells_r     <= '0;
      cmv_r       <= '0;
      settled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      ft_r        <= ft_nxt;
      status_r    <= status_nxt;
      cells_r     <= cells_nxt;
      cmv_r       <= cmv_nxt;
      settled_r   <= settled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ps_r   <= ps_nxt;
    ts_r   <= ts_nxt;
    raw_r  <= raw_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    inst_r <= inst_nxt;
    cdiv_r <= cdiv_nxt;
    k_r    <= k_nxt;
    lim_r  <= lim_nxt;
    if (out_load) begin
      o_status_r  <= status_r;
      o_cells_r   <= cells_r;
      o_pack_r    <= fp_r[23:8];
      o_cell_r    <= cmv_r;
      o_settled_r <= settled_r;
      o_temp_r    <= ft_r[26:8];
    end
  end

  assign out_req.valid          = out_valid_r;
  assign out_req.pack_status    = o_status_r;
  assign out_req.cell_count     = o_cells_r;
  assign out_req.pack_mv        = o_pack_r;
  assign out_req.cell_mv        = o_cell_r;
  assign out_req.is_settled     = o_settled_r;
  assign out_req.die_temp_centi = o_temp_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_RAW))
    else $error("accepted request did not start the sequence");

  a_nc_cells: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == bcm_pkg::STAT_NC) |-> (cells_r == 3'd0))
    else $error("cell count kept while not connected");

  a_conn_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != bcm_pkg::STAT_NC) |-> settled_r)
    else $error("connected without settled flag");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the final step");

endmodule
`default_nettype wire

/* hdl/battery_cell_monitor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery cell monitor
// Pack voltage and die temperature supervisor with cell counting.
// ----------------------------------------------------------------------------
// A request is accepted only in idle and then steps through the sequencer states
// in order; on the step that connects, the cell counter runs as well, and the
// final step waits while an earlier result is still not taken. The eight products
// go one after another through the single shared multiplier.
// Reset (rst_n low, synchronous): registers return to their defaults, filters
// and status clear to not connected, and no result is pending.
// ----------------------------------------------------------------------------
module battery_cell_monitor #(
  parameter int MAX_CELLS = bcm_pkg::MAX_CELLS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [bcm_pkg::CFG_AW-1:0]   paddr,
  input  wire  [bcm_pkg::CFG_DW-1:0]   pwdata,
  output logic [bcm_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  // Sample requests in, status results out
  bcm_in_if.sink                       in_req,
  bcm_out_if.source                    out_req
);

  // Register values shared with the sequencer. Writes are only expected
  // while no request is in flight, so the datapath reads them directly.
  bcm_pkg::cfg_t    cfg;

  // The one multiplier that every product goes through. Its product is
  // registered, so the sequencer issues a pair of operands in one step and
  // consumes the product in the next while issuing the following pair.
  bcm_pkg::mul_op_t mul_op;
  logic signed [62:0] prod;

  bcm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcm_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  // The sequencer scales the pack sample, runs both Q15 low-pass filters,
  // converts the temperature through a reciprocal multiply by 1/4095,
  // divides the pack voltage by the cell count with a reciprocal table,
  // counts cells one compare per cycle and updates the status. The result
  // register lets a new request in while the previous result still waits.
  bcm_seq #(
    .MAX_CELLS (MAX_CELLS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .mul_op  (mul_op),
    .prod    (prod),
    .in_req  (in_req),
    .out_req (out_req)
  );

endmodule
`default_nettype wire
